### design/b2b_pkg.sv
// ----------------------------------------------------------------------------
// b2b_pkg: shared types and constants for the keyed hash engine
// Holds the initial chain words, the message schedule table and the types
// that pass between the sequencer and the mixing datapath.
// ----------------------------------------------------------------------------
package b2b_pkg;

	localparam int unsigned ROUNDS_DEFAULT = 12;
	localparam logic [31:0] PARAM_BASE     = 32'h0101_0000;
	localparam logic [7:0]  BLOCK_BYTES    = 8'd128;

	localparam logic [6:0] KEY_LENGTH_RESET    = 7'd0;
	localparam logic [6:0] DIGEST_LENGTH_RESET = 7'd64;

	// Register indexes of the configuration port.
	localparam logic [0:0] REG_KEY_LENGTH    = 1'b0;
	localparam logic [0:0] REG_DIGEST_LENGTH = 1'b1;

	typedef logic [63:0] word_t;

	function automatic word_t iv_word(input logic [2:0] idx);
		word_t w;
		unique case (idx)
			3'd0: w = 64'h6a09e667f3bcc908;
			3'd1: w = 64'hbb67ae8584caa73b;
			3'd2: w = 64'h3c6ef372fe94f82b;
			3'd3: w = 64'ha54ff53a5f1d36f1;
			3'd4: w = 64'h510e527fade682d1;
			3'd5: w = 64'h9b05688c2b3e6c1f;
			3'd6: w = 64'h1f83d9abfb41bd6b;
			default: w = 64'h5be0cd19137e2179;
		endcase
		return w;
	endfunction

	// Message schedule: the word index used at position pos of round class rc.
	function automatic logic [3:0] sigma(input logic [3:0] rc, input logic [3:0] pos);
		logic [63:0] row;
		unique case (rc)
			4'd0: row = 64'hFEDCBA9876543210;
			4'd1: row = 64'h357B20C16DF984AE;
			4'd2: row = 64'h491763EADF250C8B;
			4'd3: row = 64'h8F04A562EBCD1397;
			4'd4: row = 64'hD386CB1EFA427509;
			4'd5: row = 64'h91EF57D438B0A6C2;
			4'd6: row = 64'hB8293670A4DEF15C;
			4'd7: row = 64'hA2684F05931CE7BD;
			4'd8: row = 64'h5A417D2C803B9EF6;
			default: row = 64'h0DC3E9BF5167482A;
		endcase
		return row[{pos, 2'b00} +: 4];
	endfunction

	// Word indexes a, b, c, d of each of the eight G steps of a round.
	function automatic logic [15:0] g_lanes(input logic [2:0] g);
		logic [15:0] r;
		unique case (g)
			3'd0: r = {4'd0, 4'd4, 4'd8,  4'd12};
			3'd1: r = {4'd1, 4'd5, 4'd9,  4'd13};
			3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
			3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
			3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
			3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
			3'd6: r = {4'd2, 4'd7, 4'd8,  4'd13};
			default: r = {4'd3, 4'd4, 4'd9, 4'd14};
		endcase
		return r;
	endfunction

	// Operands for one half G step.
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t m;
		logic  second;
	} g_in_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} g_out_t;

endpackage

### design/b2b_if.sv
// ----------------------------------------------------------------------------
// b2b_if: stream and configuration channels
// Valid/ready channels for message items, digest words and register writes.
// ----------------------------------------------------------------------------
interface b2b_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] message_word;
	logic [3:0]  valid_bytes;
	logic        final_item;
	modport source (output valid, message_word, valid_bytes, final_item, input ready);
	modport sink   (input valid, message_word, valid_bytes, final_item, output ready);
endinterface

interface b2b_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  word_number;
	logic        last_word;
	logic        overflow_error;
	modport source (output valid, digest_word, word_number, last_word, overflow_error,
		input ready);
	modport sink   (input valid, digest_word, word_number, last_word, overflow_error,
		output ready);
endinterface

interface b2b_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [6:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### design/b2b_g_half.sv
// ----------------------------------------------------------------------------
// b2b_g_half: one half of the G mixing function
// Three adds, two xors and two rotations; the shared unit of the engine.
// ----------------------------------------------------------------------------
module b2b_g_half (
	input  b2b_pkg::g_in_t  op,
	output b2b_pkg::g_out_t res
);
	b2b_pkg::word_t a1, d1, c1, b1, dx, bx;

	always_comb begin
		a1 = op.a + op.b + op.m;
		dx = op.d ^ a1;
		// First half rotates by 32 and 24, second half by 16 and 63.
		d1 = op.second ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
		c1 = op.c + d1;
		bx = op.b ^ c1;
		b1 = op.second ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
		res.a = a1;
		res.b = b1;
		res.c = c1;
		res.d = d1;
	end
endmodule

### design/blake2b_keyed_hash_top.sv
// ----------------------------------------------------------------------------
// blake2b_keyed_hash_top: iterative BLAKE2b engine
// Byte-packs message items into a block buffer and compresses each block with
// one shared half-G unit under a small sequencer.
// ----------------------------------------------------------------------------
// An item is packed one byte per cycle, paused while a full buffer is compressed;
// the next item is taken only once packing is done and the engine is idle again.
// After a final item the block is compressed as the last one, and its digest
// is then offered as eight output transfers.
// Mixing runs one half-G step per cycle, so a 128-byte block takes 16*ROUNDS
// half-G steps. Reset: arst_n clears control state, buffer and counters, and
// loads the chain from the reset register values.
module blake2b_keyed_hash_top #(
	parameter int unsigned ROUNDS = b2b_pkg::ROUNDS_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	b2b_in_if.sink       in_ch,
	b2b_out_if.source    out_ch,
	b2b_cfg_if.sink      cfg
);
	localparam int unsigned RW = $clog2(ROUNDS + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PACK  = 6'b000010,
		ST_INIT  = 6'b000100,
		ST_MIX   = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;

	logic [6:0]  key_len_q, dig_len_q;
	b2b_pkg::word_t chain_q [8];
	b2b_pkg::word_t buf_q   [16];
	b2b_pkg::word_t v_q     [16];
	logic [7:0]  fill_q;
	b2b_pkg::word_t cnt_lo_q, cnt_hi_q;
	logic        ovf_q;

	// Item being packed.
	b2b_pkg::word_t word_q;
	logic [3:0]  left_q;
	logic        fin_q;
	logic        last_blk_q;

	// Mixing sequencer.
	logic [RW-1:0] round_q;
	logic [2:0]    gstep_q;
	logic          half_q;
	logic [3:0]    rclass_q;
	logic [2:0]    outk_q;

	b2b_pkg::g_in_t  g_op;
	b2b_pkg::g_out_t g_res;
	logic [3:0] ia, ib, ic, id;

	b2b_g_half u_g (.op(g_op), .res(g_res));

	always_comb begin
		{ia, ib, ic, id} = b2b_pkg::g_lanes(gstep_q);
		g_op.a = v_q[ia];
		g_op.b = v_q[ib];
		g_op.c = v_q[ic];
		g_op.d = v_q[id];
		g_op.m = buf_q[b2b_pkg::sigma(rclass_q, {gstep_q, half_q})];
		g_op.second = half_q;
	end

	// A configuration write takes precedence over a message item in the same
	// cycle, so the input side is held off while one is offered.
	assign in_ch.ready  = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready    = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.digest_word    = chain_q[outk_q];
	assign out_ch.word_number    = outk_q;
	assign out_ch.last_word      = (outk_q == 3'd7);
	assign out_ch.overflow_error = ovf_q;

	// Count added by the compression that is about to start.
	b2b_pkg::word_t add_n, lo_next;
	logic carry;
	always_comb begin
		add_n = {56'd0, fill_q};
		{carry, lo_next} = {1'b0, cnt_lo_q} + {1'b0, add_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			key_len_q <= b2b_pkg::KEY_LENGTH_RESET;
			dig_len_q <= b2b_pkg::DIGEST_LENGTH_RESET;
			fill_q    <= '0;
			cnt_lo_q  <= '0;
			cnt_hi_q  <= '0;
			ovf_q     <= 1'b0;
			left_q    <= '0;
			fin_q     <= 1'b0;
			last_blk_q <= 1'b0;
			round_q   <= '0;
			gstep_q   <= '0;
			half_q    <= 1'b0;
			rclass_q  <= '0;
			outk_q    <= '0;
			for (int i = 0; i < 16; i++) buf_q[i] <= '0;
			for (int i = 1; i < 8; i++) chain_q[i] <= b2b_pkg::iv_word(3'(i));
			chain_q[0] <= b2b_pkg::iv_word(3'd0) ^ {32'd0, b2b_pkg::PARAM_BASE}
				^ {49'd0, b2b_pkg::KEY_LENGTH_RESET, 8'd0}
				^ {57'd0, b2b_pkg::DIGEST_LENGTH_RESET};
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg.valid) begin
						// A write re-initialises the engine from the new values.
						logic [6:0] kl, dl;
						kl = (cfg.index == b2b_pkg::REG_KEY_LENGTH) ? cfg.data : key_len_q;
						dl = (cfg.index == b2b_pkg::REG_DIGEST_LENGTH) ? cfg.data : dig_len_q;
						key_len_q <= kl;
						dig_len_q <= dl;
						for (int i = 0; i < 16; i++) buf_q[i] <= '0;
						for (int i = 1; i < 8; i++) chain_q[i] <= b2b_pkg::iv_word(3'(i));
						chain_q[0] <= b2b_pkg::iv_word(3'd0)
							^ {32'd0, b2b_pkg::PARAM_BASE} ^ {49'd0, kl, 8'd0} ^ {57'd0, dl};
						fill_q   <= '0;
						cnt_lo_q <= '0;
						cnt_hi_q <= '0;
						ovf_q    <= 1'b0;
					end else if (in_ch.valid) begin
						word_q <= in_ch.message_word;
						left_q <= (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
						fin_q  <= in_ch.final_item;
						state_q <= ST_PACK;
					end
				end
				ST_PACK: begin
					// One byte per cycle; a full buffer is compressed first.
					if (left_q != 4'd0) begin
						if (fill_q == b2b_pkg::BLOCK_BYTES) begin
							last_blk_q <= 1'b0;
							state_q <= ST_INIT;
						end else begin
							buf_q[fill_q[6:3]][{fill_q[2:0], 3'b000} +: 8] <= word_q[7:0];
							word_q <= {8'd0, word_q[63:8]};
							left_q <= left_q - 4'd1;
							fill_q <= fill_q + 8'd1;
						end
					end else if (fin_q) begin
						last_blk_q <= 1'b1;
						state_q <= ST_INIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INIT: begin
					cnt_lo_q <= lo_next;
					if (carry) begin
						cnt_hi_q <= cnt_hi_q + 64'd1;
						if (cnt_hi_q == '1) ovf_q <= 1'b1;
					end
					for (int i = 0; i < 8; i++) begin
						v_q[i]   <= chain_q[i];
						v_q[i+8] <= b2b_pkg::iv_word(3'(i));
					end
					v_q[12] <= b2b_pkg::iv_word(3'd4) ^ lo_next;
					v_q[13] <= b2b_pkg::iv_word(3'd5) ^ (cnt_hi_q + {63'd0, carry});
					v_q[14] <= last_blk_q ? ~b2b_pkg::iv_word(3'd6) : b2b_pkg::iv_word(3'd6);
					round_q  <= '0;
					rclass_q <= '0;
					gstep_q  <= '0;
					half_q   <= 1'b0;
					state_q  <= ST_MIX;
				end
				ST_MIX: begin
					v_q[ia] <= g_res.a;
					v_q[ib] <= g_res.b;
					v_q[ic] <= g_res.c;
					v_q[id] <= g_res.d;
					half_q <= ~half_q;
					if (half_q) begin
						gstep_q <= gstep_q + 3'd1;
						if (gstep_q == 3'd7) begin
							rclass_q <= (rclass_q == 4'd9) ? 4'd0 : rclass_q + 4'd1;
							round_q  <= round_q + RW'(1);
							if (round_q == RW'(ROUNDS - 1)) state_q <= ST_FOLD;
						end
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i+8];
					for (int i = 0; i < 16; i++) buf_q[i] <= '0;
					fill_q <= '0;
					outk_q <= '0;
					state_q <= last_blk_q ? ST_OUT : ST_PACK;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						outk_q <= outk_q + 3'd1;
						if (outk_q == 3'd7) begin
							for (int i = 1; i < 8; i++) chain_q[i] <= b2b_pkg::iv_word(3'(i));
							chain_q[0] <= b2b_pkg::iv_word(3'd0)
								^ {32'd0, b2b_pkg::PARAM_BASE} ^ {49'd0, key_len_q, 8'd0}
								^ {57'd0, dig_len_q};
							cnt_lo_q <= '0;
							cnt_hi_q <= '0;
							ovf_q    <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### design/b2b_checker.sv
// ----------------------------------------------------------------------------
// b2b_checker: port-level checks for the hash engine
// Watches the handshakes and digest word numbering at the top level.
// ----------------------------------------------------------------------------
module b2b_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_number,
	input logic       last_word,
	input logic       cfg_ready
);
	// No input is taken while a digest is being delivered.
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready during digest output");

	// The last-word mark matches word seven.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_number == 3'd7)))
		else $error("last_word out of place");

	// Digest words count up by one per transfer.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> (out_valid &&
		word_number == $past(word_number) + 3'd1)) else $error("word order broken");

	// An input transfer makes the block busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !cfg_ready))
		else $error("ready after input transfer");
endmodule

bind blake2b_keyed_hash_top b2b_checker u_b2b_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_number(out_ch.word_number), .last_word(out_ch.last_word),
	.cfg_ready(cfg.ready)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keyed BLAKE2b hash engine
// A short table of directed items and register writes is followed by random
// keyed and unkeyed messages. Each digest word is checked against a bit-accurate
// software model in the bench, bar word 0 of two rows set to published digests.
// ----------------------------------------------------------------------------
module testbench;

	localparam int  CLK_HALF       = 2;
	localparam int  RESET_CYCLES   = 6;
	localparam int  RANDOM_ITEMS   = 205;
	localparam int  IDLE_PERCENT   = 23;
	localparam int  HOLD_CYCLES    = 400;
	localparam int  SETTLE_CYCLES  = 600;
	localparam int  CYCLE_LIMIT    = 1_500_000;

	// Kinds of rows in the directed table.
	typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        fin;
		logic [0:0]  reg_index;
		logic [6:0]  reg_data;
		bit          has_known;
		logic [63:0] known_word0;
	} row_t;

	typedef struct {
		logic [63:0] digest;
		logic [2:0]  number;
		logic        last;
		logic        ovf;
	} digest_word_t;

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
		64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

	localparam logic [3:0] SCHED [10][16] = '{
		'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
		'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
		'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
		'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
		'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
		'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
		'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
		'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
		'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
		'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

	// Work vector lanes a, b, c, d of the eight mixing steps of one round.
	localparam int LANE_A [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
	localparam int LANE_B [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
	localparam int LANE_C [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
	localparam int LANE_D [8] = '{12, 13, 14, 15, 15, 12, 13, 14};

	logic clk;
	logic arst_n;

	b2b_in_if  in_ch ();
	b2b_out_if out_ch ();
	b2b_cfg_if cfg_ch ();

	blake2b_keyed_hash_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Model state of the hash engine.
	logic [6:0]  key_len_reg;
	logic [6:0]  digest_len_reg;
	logic [63:0] chain [8];
	logic [63:0] msg_block [16];
	int          block_fill;
	logic [63:0] bytes_lo;
	logic [63:0] bytes_hi;
	bit          wrapped;

	digest_word_t pending_digest [$];

	int  error_count;
	int  cycle_count;
	int  items_sent;
	int  messages_done;
	int  blocks_compressed;
	int  config_writes;
	bit  calm;
	bit  hold_start;
	int  hold_left;

	function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// Reload the chain from the configured parameter word and clear the message.
	function automatic void restart_hash();
		for (int i = 0; i < 8; i++)
			chain[i] = IV[i];
		chain[0] ^= {32'h0, b2b_pkg::PARAM_BASE} ^ ({57'h0, key_len_reg} << 8)
			^ {57'h0, digest_len_reg};
		for (int i = 0; i < 16; i++)
			msg_block[i] = '0;
		block_fill = 0;
		bytes_lo = '0;
		bytes_hi = '0;
		wrapped = 0;
	endfunction

	function automatic void compress_block(input logic [63:0] added, input bit last);
		logic [63:0] v [16];
		logic [63:0] x;
		logic [63:0] y;
		int a, b, c, d;
		bytes_lo += added;
		if (bytes_lo < added) begin
			bytes_hi += 1;
			if (bytes_hi == 0)
				wrapped = 1;
		end
		for (int i = 0; i < 8; i++) begin
			v[i] = chain[i];
			v[i + 8] = IV[i];
		end
		v[12] ^= bytes_lo;
		v[13] ^= bytes_hi;
		if (last)
			v[14] = ~v[14];
		for (int r = 0; r < b2b_pkg::ROUNDS_DEFAULT; r++) begin
			for (int g = 0; g < 8; g++) begin
				a = LANE_A[g];
				b = LANE_B[g];
				c = LANE_C[g];
				d = LANE_D[g];
				x = msg_block[SCHED[r % 10][2 * g]];
				y = msg_block[SCHED[r % 10][2 * g + 1]];
				v[a] = v[a] + v[b] + x;
				v[d] = rotr64(v[d] ^ v[a], 32);
				v[c] = v[c] + v[d];
				v[b] = rotr64(v[b] ^ v[c], 24);
				v[a] = v[a] + v[b] + y;
				v[d] = rotr64(v[d] ^ v[a], 16);
				v[c] = v[c] + v[d];
				v[b] = rotr64(v[b] ^ v[c], 63);
			end
		end
		for (int i = 0; i < 8; i++) begin
			chain[i] ^= v[i] ^ v[i + 8];
			msg_block[2 * i] = '0;
			msg_block[2 * i + 1] = '0;
		end
		block_fill = 0;
		blocks_compressed++;
	endfunction

	// Absorb one accepted item; a final item queues the eight digest words.
	function automatic void absorb_item(input logic [63:0] word, input logic [3:0] nbytes,
		input logic fin);
		int count;
		digest_word_t dw;
		count = (nbytes > 8) ? 8 : nbytes;
		for (int i = 0; i < count; i++) begin
			if (block_fill >= 128)
				compress_block(64'd128, 0);
			msg_block[block_fill / 8] |= ((word >> (8 * i)) & 64'hFF) << (8 * (block_fill % 8));
			block_fill++;
		end
		if (fin) begin
			compress_block(64'(block_fill), 1);
			for (int k = 0; k < 8; k++) begin
				dw.digest = chain[k];
				dw.number = 3'(k);
				dw.last = (k == 7);
				dw.ovf = wrapped;
				pending_digest.push_back(dw);
			end
			messages_done++;
			restart_hash();
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// Clock and cycle limit.
	initial begin
		clk = 0;
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench: errors");
			$finish;
		end
	end

	// Receiver: random stalls, calm stretches, and one long hold-off counted
	// here so that the engine backs up and stalls its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_start) begin
			hold_start = 0;
			hold_left <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Every digest transfer is compared with the oldest pending word.
	always @(posedge clk) begin
		digest_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_digest.size() == 0) begin
				report_mismatch("unexpected digest word", out_ch.digest_word, 64'h0);
			end else begin
				want = pending_digest.pop_front();
				if (out_ch.digest_word !== want.digest)
					report_mismatch("digest_word", out_ch.digest_word, want.digest);
				if (out_ch.word_number !== want.number)
					report_mismatch("word_number", 64'(out_ch.word_number), 64'(want.number));
				if (out_ch.last_word !== want.last)
					report_mismatch("last_word", 64'(out_ch.last_word), 64'(want.last));
				if (out_ch.overflow_error !== want.ovf)
					report_mismatch("overflow_error", 64'(out_ch.overflow_error), 64'(want.ovf));
			end
		end
	end

	// Offer one item, idling first at random, and hold it until the transfer.
	// Valid stays high afterwards, so it does not drop between back-to-back items.
	task automatic send_item(input logic [63:0] word, input logic [3:0] nbytes,
		input logic fin);
		int gap;
		if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			gap = $urandom_range(1, 6);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.message_word <= word;
		in_ch.valid_bytes <= nbytes;
		in_ch.final_item <= fin;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		absorb_item(word, nbytes, fin);
		items_sent++;
	endtask

	// Register writes happen only with the engine idle: every pending digest
	// word has arrived and any trailing compression has had time to finish.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_digest.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; valid drops for a cycle before the next write.
	task automatic write_reg(input logic [0:0] index, input logic [6:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (index == b2b_pkg::REG_KEY_LENGTH)
			key_len_reg = data;
		else
			digest_len_reg = data;
		restart_hash();
		config_writes++;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Directed rows. The two known digests are the published BLAKE2b-512 values
	// of the empty message and of "abc", first little-endian word of each.
	row_t directed [] = '{
		'{ROW_ITEM, 64'h0, 4'd0, 1'b1, 1'b0, 7'd0, 1'b1, 64'h03590142f7026a78},
		'{ROW_ITEM, 64'h636261, 4'd3, 1'b1, 1'b0, 7'd0, 1'b1, 64'h0d4d1c983fa580ba},
		'{ROW_ITEM, 64'hdead_beef_0bad_f00d, 4'd0, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h0123_4567_89ab_cdef, 4'd15, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h0, 4'd8, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'ha5a5_5a5a_c3c3_3c3c, 4'd9, 1'b1, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h1122_3344_5566_7788, 4'd5, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h99aa_bbcc_ddee_ff00, 4'd3, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h8000_0000_0000_0001, 4'd1, 1'b0, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h7fff_ffff_ffff_fffe, 4'd8, 1'b1, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_CFG, 64'h0, 4'd0, 1'b0, b2b_pkg::REG_DIGEST_LENGTH, 7'd1, 1'b0, 64'h0},
		'{ROW_ITEM, 64'hffff_ffff_ffff_ffff, 4'd12, 1'b1, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_CFG, 64'h0, 4'd0, 1'b0, b2b_pkg::REG_KEY_LENGTH, 7'd127, 1'b0, 64'h0},
		'{ROW_CFG, 64'h0, 4'd0, 1'b0, b2b_pkg::REG_DIGEST_LENGTH, 7'd0, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h0, 4'd7, 1'b1, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_CFG, 64'h0, 4'd0, 1'b0, b2b_pkg::REG_DIGEST_LENGTH, 7'd127, 1'b0, 64'h0},
		'{ROW_ITEM, 64'h5555_aaaa_5555_aaaa, 4'd6, 1'b1, 1'b0, 7'd0, 1'b0, 64'h0},
		'{ROW_CFG, 64'h0, 4'd0, 1'b0, b2b_pkg::REG_KEY_LENGTH, 7'd0, 1'b0, 64'h0},
		'{ROW_CFG, 64'h0, 4'd0, 1'b0, b2b_pkg::REG_DIGEST_LENGTH, 7'd64, 1'b0, 64'h0}
	};

	initial begin
		int key_len;
		int words;
		logic [63:0] kw;
		logic [3:0] nb;
		int rand_items;
		int phase;
		digest_word_t first;

		in_ch.valid <= 1'b0;
		in_ch.message_word <= '0;
		in_ch.valid_bytes <= '0;
		in_ch.final_item <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= b2b_pkg::REG_KEY_LENGTH;
		cfg_ch.data <= '0;
		arst_n = 1'b0;
		error_count = 0;
		cycle_count = 0;
		items_sent = 0;
		messages_done = 0;
		blocks_compressed = 0;
		config_writes = 0;
		calm = 0;
		hold_start = 0;
		hold_left = 0;
		key_len_reg = b2b_pkg::KEY_LENGTH_RESET;
		digest_len_reg = b2b_pkg::DIGEST_LENGTH_RESET;
		restart_hash();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. A row with a known digest replaces the model's word 0.
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(directed[i].reg_index, directed[i].reg_data);
			end else begin
				send_item(directed[i].word, directed[i].nbytes, directed[i].fin);
				if (directed[i].has_known) begin
					first = pending_digest[pending_digest.size() - 8];
					first.digest = directed[i].known_word0;
					pending_digest[pending_digest.size() - 8] = first;
				end
			end
		end

		// Random messages. The first one ends into a long receiver hold-off
		// while the sender keeps offering the next message; phases three to
		// five run without idling.
		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (phase == 0 || (phase != 1 && $urandom_range(3) == 0)) begin
				// The sender pauses here until every pending digest word is in.
				wait_idle();
				case ($urandom_range(3))
					0: key_len = 0;
					1: key_len = 64;
					default: key_len = $urandom_range(64);
				endcase
				write_reg(b2b_pkg::REG_KEY_LENGTH, 7'(key_len));
				case ($urandom_range(3))
					0: write_reg(b2b_pkg::REG_DIGEST_LENGTH, 7'd1);
					1: write_reg(b2b_pkg::REG_DIGEST_LENGTH, 7'd64);
					default: write_reg(b2b_pkg::REG_DIGEST_LENGTH, 7'($urandom_range(1, 64)));
				endcase
			end
			calm = (phase >= 3 && phase <= 5);
			// Key block: the key bytes zero-padded to one full block.
			if (key_len_reg != 0) begin
				for (int w = 0; w < 16; w++) begin
					kw = rand64();
					for (int b = 0; b < 8; b++)
						if (w * 8 + b >= key_len_reg)
							kw[8 * b +: 8] = 8'h0;
					send_item(kw, 4'd8, 1'b0);
					rand_items++;
				end
			end
			// Mostly short messages, now and then long enough to span blocks.
			words = ($urandom_range(5) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
			for (int w = 0; w < words; w++) begin
				nb = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
				send_item(rand64(), nb, 1'b0);
				rand_items++;
			end
			nb = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
			if (phase == 0)
				hold_start = 1;
			send_item(rand64(), nb, 1'b1);
			rand_items++;
			phase++;
		end
		in_ch.valid <= 1'b0;
		calm = 0;

		@(posedge clk);
		while (pending_digest.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d items, %0d messages, %0d compressions, %0d register writes",
			items_sent, messages_done, blocks_compressed, config_writes);
		$display("mismatches: %0d", error_count);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

### sim.f
design/b2b_pkg.sv
design/b2b_if.sv
design/b2b_g_half.sv
design/blake2b_keyed_hash_top.sv
design/b2b_checker.sv
verif/testbench.sv
